// ----- rtl/pqtd_pkg.sv -----
package pqtd_pkg;

    // Field widths of the item and result channels
    localparam int FUNC_W  = 2;
    localparam int SUB_W   = 3;
    localparam int CODE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 40;

    // Geometry of the distance tables
    localparam int SUBSPACES  = 8;
    localparam int CENTROIDS  = 256;
    localparam int SUB_IDX_W  = $clog2(SUBSPACES);
    localparam int CENT_IDX_W = $clog2(CENTROIDS);
    localparam int PAIR_AW    = SUB_IDX_W + 2 * CENT_IDX_W;
    localparam int QUERY_AW   = SUB_IDX_W + CENT_IDX_W;
    localparam int PAIR_DEPTH  = 1 << PAIR_AW;
    localparam int QUERY_DEPTH = 1 << QUERY_AW;

    // Item operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VECTOR = 2'd2;

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [SUB_W-1:0]      t_sub;
    typedef logic [CODE_W-1:0]     t_code;
    typedef logic [VALUE_W-1:0]    t_value;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [PAIR_AW-1:0]    t_pair_addr;
    typedef logic [QUERY_AW-1:0]   t_query_addr;
    typedef logic [CENT_IDX_W-1:0] t_cent_idx;
    typedef logic [SUB_IDX_W-1:0]  t_sub_idx;

endpackage

// ----- rtl/pqtd_in_if.sv -----
interface pqtd_in_if;
    logic             valid;
    logic             ready;
    pqtd_pkg::t_func  func;
    pqtd_pkg::t_sub   sub;
    pqtd_pkg::t_code  row;
    pqtd_pkg::t_code  code;
    pqtd_pkg::t_value value;
    logic             last;

    modport source (output valid, func, sub, row, code, value, last, input ready);
    modport sink   (input valid, func, sub, row, code, value, last, output ready);
endinterface

// ----- rtl/pqtd_out_if.sv -----
interface pqtd_out_if;
    logic           valid;
    logic           ready;
    pqtd_pkg::t_sum distance;
    logic           from_query;

    modport source (output valid, distance, from_query, input ready);
    modport sink   (input valid, distance, from_query, output ready);
endinterface

// ----- rtl/pq_table_distance_accumulator.sv -----
// Product-quantization distance engine, unsigned Q16.16 table entries, Q24.16 sums.
// Input channel i_in carries one item per transfer: func selects a table write,
// a query code or a vector code to score. Output channel o_out carries one
// summed distance per vector, on the vector code marked last.
// Work per item, all set by one sequencer over two single-port-read memories:
//   table write : written straight into the pair store.
//   vector code : one registered lookup, then one saturating 40-bit add;
//                 the last code then loads the output register.
//   query code  : the row is copied one entry a cycle through the pair store
//                 read port into the query store, then the copy drains.
// Reset (i_rst_n low, synchronous) clears the sequencer, the query-ready flag,
// the running sum and the output valid. Both stores keep their contents and
// read as undefined until written; there is no clearing pass.
// The output register holds a result while the receiver stalls; the block keeps
// taking items and stalls only if a second result is ready before the first one
// has been transferred.
module pq_table_distance_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pqtd_in_if.sink     i_in,
    pqtd_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COPY  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Stores
    logic [pqtd_pkg::VALUE_W-1:0] r_pair_mem  [pqtd_pkg::PAIR_DEPTH];
    logic [pqtd_pkg::VALUE_W-1:0] r_query_mem [pqtd_pkg::QUERY_DEPTH];

    // Sequencer and datapath registers
    logic [2:0]                r_state,       n_state;
    pqtd_pkg::t_cent_idx       r_cnt,         n_cnt;
    pqtd_pkg::t_sub_idx        r_sub,         n_sub;
    pqtd_pkg::t_cent_idx       r_code,        n_code;
    logic                      r_wr_vld,      n_wr_vld;
    pqtd_pkg::t_cent_idx       r_wr_idx,      n_wr_idx;
    logic                      r_query_ready, n_query_ready;
    pqtd_pkg::t_sum            r_sum,         n_sum;
    logic                      r_use_query,   n_use_query;
    logic                      r_ok,          n_ok;
    logic                      r_last,        n_last;
    logic                      r_out_valid,   n_out_valid;
    pqtd_pkg::t_sum            r_distance,    n_distance;
    logic                      r_from_query,  n_from_query;
    pqtd_pkg::t_value          r_pair_q;
    pqtd_pkg::t_value          r_query_q;

    logic                      in_xfer;
    logic                      sub_ok;
    logic                      code_ok;
    logic                      row_ok;
    pqtd_pkg::t_sub_idx        in_sub;
    pqtd_pkg::t_cent_idx       in_code;
    pqtd_pkg::t_cent_idx       in_row;
    logic                      pair_we;
    pqtd_pkg::t_pair_addr      pair_wr_addr;
    pqtd_pkg::t_pair_addr      pair_rd_addr;
    pqtd_pkg::t_query_addr     query_rd_addr;
    pqtd_pkg::t_value          operand;
    logic [pqtd_pkg::SUM_W:0]  sum_ext;
    pqtd_pkg::t_sum            sum_sat;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    assign sub_ok  = (int'(i_in.sub)  < pqtd_pkg::SUBSPACES);
    assign code_ok = (int'(i_in.code) < pqtd_pkg::CENTROIDS);
    assign row_ok  = (int'(i_in.row)  < pqtd_pkg::CENTROIDS);

    assign in_sub  = i_in.sub[pqtd_pkg::SUB_IDX_W-1:0];
    assign in_code = i_in.code[pqtd_pkg::CENT_IDX_W-1:0];
    assign in_row  = i_in.row[pqtd_pkg::CENT_IDX_W-1:0];

    assign pair_wr_addr  = {in_sub, in_row, in_code};
    assign query_rd_addr = {in_sub, in_code};

    // Shared adder: pick the looked-up term, add, clamp at full scale
    assign operand = r_use_query ? r_query_q : r_pair_q;
    assign sum_ext = {1'b0, r_sum}
                   + {{(pqtd_pkg::SUM_W + 1 - pqtd_pkg::VALUE_W){1'b0}}, operand};
    assign sum_sat = sum_ext[pqtd_pkg::SUM_W] ? {pqtd_pkg::SUM_W{1'b1}}
                                              : sum_ext[pqtd_pkg::SUM_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_sub         = r_sub;
        n_code        = r_code;
        n_wr_vld      = 1'b0;
        n_wr_idx      = r_cnt;
        n_query_ready = r_query_ready;
        n_sum         = r_sum;
        n_use_query   = r_use_query;
        n_ok          = r_ok;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_distance    = r_distance;
        n_from_query  = r_from_query;
        pair_we       = 1'b0;
        pair_rd_addr  = {r_sub, r_code, r_cnt};

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in.func)
                        pqtd_pkg::FUNC_WRITE: begin
                            pair_we = sub_ok && code_ok && row_ok;
                        end
                        pqtd_pkg::FUNC_QUERY: begin
                            // Flag goes up now; later items see it
                            if (i_in.last) begin
                                n_query_ready = 1'b1;
                            end
                            if (sub_ok && code_ok) begin
                                n_sub   = in_sub;
                                n_code  = in_code;
                                n_cnt   = '0;
                                n_state = S_COPY;
                            end
                        end
                        pqtd_pkg::FUNC_VECTOR: begin
                            // Diagonal entry as fallback; query entry read in parallel
                            pair_rd_addr = {in_sub, in_code, in_code};
                            n_use_query  = r_query_ready;
                            n_ok         = sub_ok && code_ok;
                            n_last       = i_in.last;
                            n_state      = S_ACC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COPY: begin
                // Read one row entry a cycle; write it into the query store in the next cycle
                n_wr_vld = 1'b1;
                n_wr_idx = r_cnt;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pqtd_pkg::CENT_IDX_W'(pqtd_pkg::CENTROIDS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_ACC: begin
                if (r_ok) begin
                    n_sum = sum_sat;
                end
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_distance   = r_sum;
                    n_from_query = r_query_ready;
                    n_sum        = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_wr_vld      <= 1'b0;
            r_query_ready <= 1'b0;
            r_sum         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_wr_vld      <= n_wr_vld;
            r_query_ready <= n_query_ready;
            r_sum         <= n_sum;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_sub        <= n_sub;
        r_code       <= n_code;
        r_wr_idx     <= n_wr_idx;
        r_use_query  <= n_use_query;
        r_ok         <= n_ok;
        r_last       <= n_last;
        r_distance   <= n_distance;
        r_from_query <= n_from_query;
    end

    // Pair store: one write port from the item channel, one registered read port
    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            r_pair_mem[pair_wr_addr] <= i_in.value;
        end
        r_pair_q <= r_pair_mem[pair_rd_addr];
    end

    // Query store: written by the row copy, read by vector codes
    always_ff @(posedge i_clk) begin
        if (r_wr_vld) begin
            r_query_mem[{r_sub, r_wr_idx}] <= r_pair_q;
        end
        r_query_q <= r_query_mem[query_rd_addr];
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.distance   = r_distance;
    assign o_out.from_query = r_from_query;

    // A row copy runs to the end before anything else
    a_copy_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |=> (r_state == S_COPY || r_state == S_DRAIN))
        else $error("row copy left early");

    // Query store writes only trail copy reads
    a_write_trails_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_vld |-> $past(r_state == S_COPY))
        else $error("query store write outside a row copy");

    // Loading a result clears the sum and raises valid
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_IDLE) |=> (r_out_valid && r_sum == '0))
        else $error("emit did not load output or clear sum");

    // A code that is not last never produces a result
    a_no_early_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && !r_last) |=> (r_state == S_IDLE))
        else $error("non-last vector code headed to emit");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the product-quantization distance engine.
// Table writes fill the pair-distance store, query codes copy whole rows into the
// query table, and vector codes are scored either from the query table or from
// the diagonal fallback. A bench-side model tracks both stores, the query-ready
// flag and the running sum, and the score of every vector is checked field by
// field against the oldest pending prediction.
module tb_top;
    import pqtd_pkg::*;

    // func 3 has no meaning: the block drops it without touching state
    localparam t_func FUNC_UNUSED  = 2'd3;
    localparam int    QUIET_LIMIT  = 4000;  // idle cycles before the run is declared hung
    localparam int    DRAIN_CYCLES = 12;    // settling margin after the last pending score is out
    localparam int    ROW_LEN      = CENTROIDS;

    typedef struct {
        t_func  func;
        t_sub   sub;
        t_code  row;
        t_code  code;
        t_value value;
        logic   last;
    } pq_item_t;

    typedef struct {
        t_sum distance;
        logic from_query;
    } score_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pqtd_in_if  in_ch ();
    pqtd_out_if out_ch ();

    pq_table_distance_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench-side copy of the engine state
    // ------------------------------------------------------------------
    bit [VALUE_W-1:0] pair_mem   [PAIR_DEPTH];
    bit               pair_seen  [PAIR_DEPTH];   // entry written at least once
    int               row_fill   [QUERY_DEPTH];  // written entries per (sub, row)
    bit [VALUE_W-1:0] query_mem  [QUERY_DEPTH];
    bit               sub_loaded [SUBSPACES];    // a query row was copied for this sub
    bit               query_armed;
    bit [SUM_W-1:0]   dist_acc;

    int full_rows [$];  // keys sub*CENTROIDS+row of completely written rows
    int diag_keys [$];  // keys sub*CENTROIDS+code with a written diagonal

    score_t expected_scores [$];
    score_t head_score;
    int     fail_count;

    // Sender pacing
    int burst_left;

    // Receiver stall pattern
    rx_mode_e rx_mode;
    int       rx_mode_left;
    bit [7:0] rx_mask;
    int       rx_phase;

    int quiet_cycles;

    // Apply one accepted item to the model; push the score a last vector code produces.
    // Indexes are always in range at these field widths, so no range test is made.
    task automatic update_distance_model(input pq_item_t it);
        int           pidx;
        int           rkey;
        bit [SUM_W:0] wide;
        score_t       s;
        case (it.func)
            FUNC_WRITE: begin
                pidx = (int'(it.sub) * CENTROIDS + int'(it.row)) * CENTROIDS + int'(it.code);
                rkey = int'(it.sub) * CENTROIDS + int'(it.row);
                if (!pair_seen[pidx]) begin
                    pair_seen[pidx] = 1'b1;
                    row_fill[rkey]++;
                    if (row_fill[rkey] == ROW_LEN)
                        full_rows.push_back(rkey);
                    if (it.row == it.code)
                        diag_keys.push_back(rkey);
                end
                pair_mem[pidx] = it.value;
            end
            FUNC_QUERY: begin
                // copy the row picked by code within sub into the query table
                pidx = (int'(it.sub) * CENTROIDS + int'(it.code)) * CENTROIDS;
                for (int j = 0; j < CENTROIDS; j++)
                    query_mem[int'(it.sub) * CENTROIDS + j] = pair_mem[pidx + j];
                sub_loaded[it.sub] = 1'b1;
                if (it.last)
                    query_armed = 1'b1;
            end
            FUNC_VECTOR: begin
                if (query_armed)
                    wide = {1'b0, dist_acc} + query_mem[int'(it.sub) * CENTROIDS + int'(it.code)];
                else
                    wide = {1'b0, dist_acc} +
                           pair_mem[(int'(it.sub) * CENTROIDS + int'(it.code)) * CENTROIDS
                                    + int'(it.code)];
                // saturate at the top of the 40-bit range
                dist_acc = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
                if (it.last) begin
                    s.distance   = dist_acc;
                    s.from_query = query_armed;
                    expected_scores.push_back(s);
                    dist_acc = '0;
                end
            end
            default: ;
        endcase
    endtask

    // Send one item: open a new burst after a random gap when the current one runs
    // out, hold the item until the transfer happens, then update the model.
    task automatic send_item(input pq_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            // one burst in four follows straight on, so long unbroken stretches occur
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.func  <= it.func;
        in_ch.sub   <= it.sub;
        in_ch.row   <= it.row;
        in_ch.code  <= it.code;
        in_ch.value <= it.value;
        in_ch.last  <= it.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        update_distance_model(it);
    endtask

    // Table values lean toward the extremes now and then
    function automatic t_value pick_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return '0;
        return t_value'($urandom);
    endfunction

    // Fields that the operation ignores still get random content
    task automatic send_write(input t_sub s, input t_code r, input t_code c, input t_value v);
        pq_item_t it;
        it.func  = FUNC_WRITE;
        it.sub   = s;
        it.row   = r;
        it.code  = c;
        it.value = v;
        it.last  = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_query(input t_sub s, input t_code c, input logic l);
        pq_item_t it;
        it.func  = FUNC_QUERY;
        it.sub   = s;
        it.row   = t_code'($urandom);
        it.code  = c;
        it.value = t_value'($urandom);
        it.last  = l;
        send_item(it);
    endtask

    task automatic send_vector(input t_sub s, input t_code c, input logic l);
        pq_item_t it;
        it.func  = FUNC_VECTOR;
        it.sub   = s;
        it.row   = t_code'($urandom);
        it.code  = c;
        it.value = t_value'($urandom);
        it.last  = l;
        send_item(it);
    endtask

    task automatic send_noise(input logic l);
        pq_item_t it;
        it.func  = FUNC_UNUSED;
        it.sub   = t_sub'($urandom);
        it.row   = t_code'($urandom);
        it.code  = t_code'($urandom);
        it.value = t_value'($urandom);
        it.last  = l;
        send_item(it);
    endtask

    // Choose a vector code whose lookup hits a written entry
    task automatic pick_scored_code(output t_sub s, output t_code c);
        int key;
        if (query_armed) begin
            // only subspaces that got a copied row hold defined query entries
            do
                s = t_sub'($urandom);
            while (!sub_loaded[s]);
            c = t_code'($urandom);
        end else begin
            key = diag_keys[$urandom_range(0, diag_keys.size() - 1)];
            s = t_sub'(key / CENTROIDS);
            c = t_code'(key % CENTROIDS);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Score through the diagonal fallback before any query exists; mix in dropped items
    task automatic test_fallback_scoring();
        send_write(3'd0, 8'h00, 8'h00, 32'h0000_0000);
        send_write(3'd7, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_write(3'd3, 8'hAA, 8'hAA, 32'h1234_5678);
        send_write(3'd4, 8'h55, 8'h55, 32'h0001_0000);
        // off-diagonal entry of the same row must not leak into the fallback
        send_write(3'd3, 8'hAA, 8'h55, 32'hDEAD_BEEF);
        send_noise(1'b1);
        send_vector(3'd7, 8'hFF, 1'b1);
        send_vector(3'd0, 8'h00, 1'b1);
        send_vector(3'd3, 8'hAA, 1'b0);
        send_noise(1'b1);   // a dropped last must not close the vector
        send_vector(3'd4, 8'h55, 1'b0);
        send_noise(1'b0);
        send_vector(3'd7, 8'hFF, 1'b1);
        // overwrite a diagonal and score it again
        send_write(3'd3, 8'hAA, 8'hAA, 32'h0000_0001);
        send_vector(3'd3, 8'hAA, 1'b1);
    endtask

    // 257 maximum distances run past 2^40-1; the next vector starts from zero again
    task automatic test_sum_saturation();
        for (int k = 0; k <= CENTROIDS; k++)
            send_vector(3'd7, 8'hFF, logic'(k == CENTROIDS));
        send_vector(3'd0, 8'h00, 1'b1);
    endtask

    // Fill one whole row of a random subspace, so queries never copy unwritten entries
    task automatic test_row_load();
        t_sub  s;
        t_code r;
        s = t_sub'($urandom);
        r = t_code'($urandom);
        for (int c = 0; c < CENTROIDS; c++)
            send_write(s, r, t_code'(c), pick_value());
    endtask

    // The ready flag comes up in the middle of a vector: early codes use the
    // diagonal, later ones the query table, and the score reports the query table
    task automatic test_query_switch();
        int    key;
        t_sub  s;
        t_code c;
        key = full_rows[0];
        send_query(t_sub'(key / CENTROIDS), t_code'(key % CENTROIDS), 1'b0);
        pick_scored_code(s, c);
        send_vector(s, c, 1'b0);
        pick_scored_code(s, c);
        send_vector(s, c, 1'b0);
        send_query(t_sub'(key / CENTROIDS), t_code'(key % CENTROIDS), 1'b1);
        pick_scored_code(s, c);
        send_vector(s, c, 1'b0);
        pick_scored_code(s, c);
        send_vector(s, c, 1'b1);
        // a second last query while already ready, then one more score
        key = full_rows[$urandom_range(0, full_rows.size() - 1)];
        send_query(t_sub'(key / CENTROIDS), t_code'(key % CENTROIDS), 1'b1);
        pick_scored_code(s, c);
        send_vector(s, c, 1'b1);
    endtask

    // Mostly well-formed traffic with random content, plus dropped items and
    // vectors broken up by them. Before the switch, queries never carry last.
    task automatic test_random_traffic(input int n_items);
        int    sent;
        int    pick;
        int    len;
        int    key;
        t_sub  s;
        t_code c;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    // rewrite inside a full row so later queries pick up new values
                    key = full_rows[$urandom_range(0, full_rows.size() - 1)];
                    send_write(t_sub'(key / CENTROIDS), t_code'(key % CENTROIDS),
                               t_code'($urandom), pick_value());
                end else if (pick < 8) begin
                    send_write(t_sub'($urandom), t_code'($urandom), t_code'($urandom),
                               pick_value());
                end else begin
                    c = t_code'($urandom);
                    send_write(t_sub'($urandom), c, c, pick_value());
                end
                sent++;
            end else if (pick < 45) begin
                key = full_rows[$urandom_range(0, full_rows.size() - 1)];
                send_query(t_sub'(key / CENTROIDS), t_code'(key % CENTROIDS),
                           logic'(query_armed && ($urandom_range(0, 3) == 0)));
                sent++;
            end else if (pick < 92) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise(1'($urandom));
                    pick_scored_code(s, c);
                    send_vector(s, c, logic'(k == len - 1));
                    sent++;
                end
            end else begin
                send_noise(1'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: check each transfer on o_out and pick the next stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_scores.size() == 0) begin
                    $display("%0t: score with none pending, actual distance %h from_query %b",
                             $time, out_ch.distance, out_ch.from_query);
                    fail_count++;
                end else begin
                    head_score = expected_scores.pop_front();
                    if (out_ch.distance !== head_score.distance) begin
                        $display("%0t: distance mismatch, expected %h, actual %h",
                                 $time, head_score.distance, out_ch.distance);
                        fail_count++;
                    end
                    if (out_ch.from_query !== head_score.from_query) begin
                        $display("%0t: from_query mismatch, expected %b, actual %b",
                                 $time, head_score.from_query, out_ch.from_query);
                        fail_count++;
                    end
                end
            end
            // advance the stall pattern; switch to a new random mode when the current one runs out
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 200);
                rx_mask      = 8'($urandom);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:    out_ch.ready <= 1'b1;
                RX_COIN:    out_ch.ready <= 1'($urandom);
                RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 7) == 0);
                RX_PATTERN: out_ch.ready <= rx_mask[rx_phase % 8];
                default:    out_ch.ready <= 1'b1;
            endcase
            rx_phase++;
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    // Watchdog: end the run when no transfer happens on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d scores pending",
                         $time, quiet_cycles, expected_scores.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        fail_count   = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_mask      = '1;
        rx_phase     = 0;
        query_armed  = 1'b0;
        dist_acc     = '0;
        // hold every input at a known value through reset
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_WRITE;
        in_ch.sub    <= '0;
        in_ch.row    <= '0;
        in_ch.code   <= '0;
        in_ch.value  <= '0;
        in_ch.last   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fallback_scoring();
        test_sum_saturation();
        test_row_load();
        test_random_traffic(50);
        test_query_switch();
        test_random_traffic(50);

        // drop valid and let every pending score come out
        in_ch.valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_scores.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
